// ===== design/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types, sizes and helpers for the LFU key/value store.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // storage sizes
  localparam int MAX_ENTRIES = 16;
  localparam int COUNT_BITS  = 16;
  localparam int WORD_W      = 32;
  localparam int CAP_W       = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);

  // configuration port
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_REG_IDX_W = CFG_ADDR_W - 2;
  localparam logic [CFG_REG_IDX_W-1:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  // commands
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // request and result payloads
  typedef struct packed {
    logic                     command;
    logic signed [WORD_W-1:0] lookup_key;
    logic signed [WORD_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] read_value;
  } out_item_t;

  // write port of the entry store
  typedef struct packed {
    logic                  we_key;
    logic                  we_val;
    logic                  we_cnt;
    logic [IDX_W-1:0]      addr;
    logic [WORD_W-1:0]     key;
    logic [WORD_W-1:0]     val;
    logic [COUNT_BITS-1:0] cnt;
  } store_wr_t;

  // result of the shared compare unit
  typedef struct packed {
    logic                  key_eq;
    logic                  cnt_lt;
    logic [COUNT_BITS-1:0] cnt_inc;
  } cmp_res_t;

  // capacity as used: zero acts as one, large values clamp to the store size
  function automatic logic [ENTRY_CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    if (c == '0) begin
      return ENTRY_CNT_W'(1);
    end
    if (32'(c) > MAX_ENTRIES) begin
      return ENTRY_CNT_W'(MAX_ENTRIES);
    end
    return ENTRY_CNT_W'(c);
  endfunction

endpackage

// ===== design/lfu_cache_replacement.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_replacement
// Fully associative key/value store with least-frequently-used eviction.
// ----------------------------------------------------------------------------
// A request on in_ is a get (look up a key) or a put (store a value under a
// key). Each request gives one result on out_: hit, and the stored value on
// a get hit, all ones on a get miss, zero for a put.
// One request is handled at a time: in_ready is high only when the sequencer
// is idle. A shared compare unit steps through the entries one per cycle,
// matching the key and tracking the least-used, oldest entry. A hit then
// bumps its use count, and on a put writes the value; a put miss on a full
// store moves each later entry down one slot, one per cycle, before the
// append. Latency from acceptance to out_valid grows with the number of
// entries held; the entry scan and the compaction set it.
// The next request can be taken in the same cycle as out_valid rises.
// The result sits in an output register; while the receiver stalls the
// next request is still taken and worked on, and the sequencer waits only
// if it finishes before the earlier result has gone.
// Reset empties the store and sets capacity to sixteen; entry arrays are
// not cleared, as only filled slots are ever read. Writing capacity on the
// cfg_ port also empties the store.
// ----------------------------------------------------------------------------
module lfu_cache_replacement (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lfu_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lfu_pkg::out_item_t                out_item,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lfu_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [lfu_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [lfu_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import lfu_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_HIT    = 3'd2;
  localparam logic [2:0] ST_MISS   = 3'd3;
  localparam logic [2:0] ST_SHIFT  = 3'd4;
  localparam logic [2:0] ST_APPEND = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic                   cmd_r, cmd_nxt;
  logic [WORD_W-1:0]      key_r, key_nxt;
  logic [WORD_W-1:0]      val_r, val_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       victim_r, victim_nxt;
  logic [COUNT_BITS-1:0]  min_r, min_nxt;
  logic [ENTRY_CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0]       cap_r;
  out_item_t              res_r, res_nxt;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic                   cfg_wr;
  logic                   in_acc;
  logic                   res_load;
  logic [IDX_W-1:0]       raddr;
  logic [WORD_W-1:0]      rd_key;
  logic [WORD_W-1:0]      rd_val;
  logic [COUNT_BITS-1:0]  rd_cnt;
  logic [ENTRY_CNT_W-1:0] idx_next_cnt;
  store_wr_t              wr;
  cmp_res_t               cmp;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_ADDR_W-1:2] == REG_CAPACITY);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_CAPACITY) ?
                      CFG_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  // handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign res_load  = (state_r == ST_RESP) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // entry store and shared compare unit
  assign idx_next_cnt = ENTRY_CNT_W'(idx_r) + ENTRY_CNT_W'(1);
  assign raddr = (state_r == ST_SHIFT) ? idx_next_cnt[IDX_W-1:0] : idx_r;

  lfu_store u_store (
    .clk    (clk),
    .wr     (wr),
    .raddr  (raddr),
    .rd_key (rd_key),
    .rd_val (rd_val),
    .rd_cnt (rd_cnt)
  );

  lfu_cmp_unit u_cmp (
    .key_a (rd_key),
    .key_b (key_r),
    .cnt_a (rd_cnt),
    .cnt_b (min_r),
    .res   (cmp)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    victim_nxt = victim_r;
    min_nxt    = min_r;
    count_nxt  = count_r;
    res_nxt    = res_r;
    wr         = '0;
    wr.addr    = idx_r;
    wr.key     = rd_key;
    wr.val     = rd_val;
    wr.cnt     = rd_cnt;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_item.command;
          key_nxt    = in_item.lookup_key;
          val_nxt    = in_item.write_value;
          idx_nxt    = '0;
          victim_nxt = '0;
          min_nxt    = '1;
          state_nxt  = (count_r == '0) ? ST_MISS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp.key_eq) begin
          state_nxt = ST_HIT;
        end else begin
          // strict less-than keeps the oldest among equal counts
          if (cmp.cnt_lt) begin
            victim_nxt = idx_r;
            min_nxt    = rd_cnt;
          end
          if (idx_next_cnt == count_r) begin
            state_nxt = ST_MISS;
          end else begin
            idx_nxt = idx_next_cnt[IDX_W-1:0];
          end
        end
      end
      ST_HIT: begin
        wr.we_cnt = 1'b1;
        wr.cnt    = cmp.cnt_inc;
        res_nxt.hit = 1'b1;
        if (cmd_r == CMD_PUT) begin
          wr.we_val = 1'b1;
          wr.val    = val_r;
          res_nxt.read_value = '0;
        end else begin
          res_nxt.read_value = rd_val;
        end
        state_nxt = ST_RESP;
      end
      ST_MISS: begin
        res_nxt.hit = 1'b0;
        if (cmd_r == CMD_GET) begin
          res_nxt.read_value = '1;
          state_nxt = ST_RESP;
        end else if (count_r >= eff_cap(cap_r)) begin
          idx_nxt   = victim_r;
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_SHIFT: begin
        // later entries close the gap left by the victim
        if (idx_next_cnt < count_r) begin
          wr.we_key = 1'b1;
          wr.we_val = 1'b1;
          wr.we_cnt = 1'b1;
          idx_nxt   = idx_next_cnt[IDX_W-1:0];
        end else begin
          count_nxt = count_r - ENTRY_CNT_W'(1);
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        wr.we_key = 1'b1;
        wr.we_val = 1'b1;
        wr.we_cnt = 1'b1;
        wr.addr   = count_r[IDX_W-1:0];
        wr.key    = key_r;
        wr.val    = val_r;
        wr.cnt    = COUNT_BITS'(1);
        count_nxt = count_r + ENTRY_CNT_W'(1);
        res_nxt.hit        = 1'b0;
        res_nxt.read_value = '0;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // a capacity write empties the store
    if (cfg_wr) begin
      count_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    victim_r <= victim_nxt;
    min_r    <= min_nxt;
    res_r    <= res_nxt;
    if (res_load) begin
      out_r <= res_r;
    end
  end

endmodule

// ===== design/lfu_store.sv =====
// ----------------------------------------------------------------------------
// lfu_store
// Entry arrays for keys, values and use counts, one write and one read port.
// ----------------------------------------------------------------------------
module lfu_store (
  input  logic                          clk,
  input  lfu_pkg::store_wr_t            wr,
  input  logic [lfu_pkg::IDX_W-1:0]     raddr,
  output logic [lfu_pkg::WORD_W-1:0]    rd_key,
  output logic [lfu_pkg::WORD_W-1:0]    rd_val,
  output logic [lfu_pkg::COUNT_BITS-1:0] rd_cnt
);
  import lfu_pkg::*;

  logic [WORD_W-1:0]     keys_r [MAX_ENTRIES];
  logic [WORD_W-1:0]     vals_r [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cnts_r [MAX_ENTRIES];

  // per-field write enables
  always_ff @(posedge clk) begin
    if (wr.we_key) begin
      keys_r[wr.addr] <= wr.key;
    end
    if (wr.we_val) begin
      vals_r[wr.addr] <= wr.val;
    end
    if (wr.we_cnt) begin
      cnts_r[wr.addr] <= wr.cnt;
    end
  end

  // single read pointer
  assign rd_key = keys_r[raddr];
  assign rd_val = vals_r[raddr];
  assign rd_cnt = cnts_r[raddr];

endmodule

// ===== design/lfu_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_cmp_unit
// Shared compare unit: key match, use count less-than and saturating bump.
// ----------------------------------------------------------------------------
module lfu_cmp_unit (
  input  logic [lfu_pkg::WORD_W-1:0]     key_a,
  input  logic [lfu_pkg::WORD_W-1:0]     key_b,
  input  logic [lfu_pkg::COUNT_BITS-1:0] cnt_a,
  input  logic [lfu_pkg::COUNT_BITS-1:0] cnt_b,
  output lfu_pkg::cmp_res_t              res
);
  import lfu_pkg::*;

  // compares
  assign res.key_eq = (key_a == key_b);
  assign res.cnt_lt = (cnt_a < cnt_b);

  // count stays put once at its maximum
  assign res.cnt_inc = (&cnt_a) ? cnt_a : cnt_a + COUNT_BITS'(1);

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LFU key/value store: directed get/put
// sequences, capacity corner settings, eviction order, heavy-use survival,
// output back-pressure and randomised traffic, all scored against an
// in-bench prediction of the store contents.
// ----------------------------------------------------------------------------
module tb;
  import lfu_pkg::*;

  localparam int TIMEOUT_LIMIT = 80_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HEAVY_BUMPS   = 30;
  localparam logic [CFG_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_item     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_item_t             out_item;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predicted store contents
  logic [CAP_W-1:0]      cap_setting;
  int                    store_fill;
  logic [WORD_W-1:0]     store_key  [MAX_ENTRIES];
  logic [WORD_W-1:0]     store_val  [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] store_uses [MAX_ENTRIES];
  out_item_t             reply_fifo [$];

  int        fail_count   = 0;
  bit        offering     = 1'b0;
  bit        src_idle_on  = 1'b1;
  bit        sink_idle_on = 1'b1;
  int        hold_request = 0;
  int        sink_wait    = 0;
  out_item_t head_reply;

  lfu_cache_replacement u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // stall length: mostly short, now and then long
  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // apply one request to the predicted store and queue its reply
  task automatic lfu_update(input in_item_t req);
    out_item_t reply;
    int        slot;
    int        victim;
    int        limit;
    bit        found;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < store_fill; i++) begin
      if (!found && store_key[i] == req.lookup_key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    // zero acts as one, anything above the store size clamps to it
    if (cap_setting == '0) limit = 1;
    else if (cap_setting > MAX_ENTRIES) limit = MAX_ENTRIES;
    else limit = int'(cap_setting);

    if (found) begin
      if (store_uses[slot] != '1) store_uses[slot] = store_uses[slot] + COUNT_BITS'(1);
      reply.hit = 1'b1;
      if (req.command == CMD_GET) begin
        reply.read_value = store_val[slot];
      end else begin
        store_val[slot]  = req.write_value;
        reply.read_value = '0;
      end
    end else begin
      reply.hit = 1'b0;
      if (req.command == CMD_GET) begin
        reply.read_value = '1;
      end else begin
        reply.read_value = '0;
        // evict least used, oldest first on a tie, then close the gap
        while (store_fill >= limit && store_fill > 0) begin
          victim = 0;
          for (int i = 1; i < store_fill; i++) begin
            if (store_uses[i] < store_uses[victim]) victim = i;
          end
          for (int i = victim; i + 1 < store_fill; i++) begin
            store_key[i]  = store_key[i + 1];
            store_val[i]  = store_val[i + 1];
            store_uses[i] = store_uses[i + 1];
          end
          store_fill--;
        end
        if (store_fill < MAX_ENTRIES) begin
          store_key[store_fill]  = req.lookup_key;
          store_val[store_fill]  = req.write_value;
          store_uses[store_fill] = COUNT_BITS'(1);
          store_fill++;
        end
      end
    end
    reply_fifo.push_back(reply);
  endtask

  task automatic lower_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // offer one request and hold it until accepted
  task automatic send_request(input logic cmd, input logic [WORD_W-1:0] key,
                              input logic [WORD_W-1:0] value);
    in_item_t req;
    int       gap;
    req.command     = cmd;
    req.lookup_key  = key;
    req.write_value = value;
    gap = (src_idle_on && $urandom_range(0, 99) < 35) ? stall_len() : 0;
    if (gap > 0) begin
      lower_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lfu_update(req);
  endtask

  task automatic wait_drained();
    lower_valid();
    while (reply_fifo.size() != 0) @(posedge clk);
  endtask

  // capacity write over the register port, store idle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAPACITY_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cap_setting = value;
    store_fill  = 0;
  endtask

  // key and value extremes, hits, misses and overwrites at reset capacity
  task automatic test_basic();
    send_request(CMD_GET, 32'h0000_0000, 32'h0);
    send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(CMD_GET, 32'h0000_0000, 32'h0);
    send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(CMD_GET, 32'h0000_0000, 32'h0);
    send_request(CMD_GET, 32'h0000_0001, 32'h0);
  endtask

  // capacity zero acts as one, oversized clamps, any write empties the store
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_request(CMD_PUT, 32'h0000_00A1, 32'h11);
    send_request(CMD_PUT, 32'h0000_00A2, 32'h22);
    send_request(CMD_GET, 32'h0000_00A1, 32'h0);
    send_request(CMD_GET, 32'h0000_00A2, 32'h0);
    write_capacity(5'd31);
    for (int i = 0; i < MAX_ENTRIES + 1; i++) send_request(CMD_PUT, 32'h100 + i, i);
    send_request(CMD_GET, 32'h100, 32'h0);
    send_request(CMD_GET, 32'h101, 32'h0);
    write_capacity(5'd16);
    send_request(CMD_GET, 32'h105, 32'h0);
    write_capacity(5'd1);
    send_request(CMD_PUT, 32'h0000_00B1, 32'h33);
    send_request(CMD_GET, 32'h0000_00B1, 32'h0);
  endtask

  // least used goes first; among equal counts the oldest goes
  task automatic test_eviction_order();
    write_capacity(5'd3);
    send_request(CMD_PUT, 32'hC1, 32'h1);
    send_request(CMD_PUT, 32'hC2, 32'h2);
    send_request(CMD_PUT, 32'hC3, 32'h3);
    send_request(CMD_GET, 32'hC2, 32'h0);
    send_request(CMD_PUT, 32'hC4, 32'h4);
    send_request(CMD_GET, 32'hC1, 32'h0);
    send_request(CMD_GET, 32'hC3, 32'h0);
    send_request(CMD_PUT, 32'hC3, 32'h5);
    send_request(CMD_PUT, 32'hC5, 32'h6);
    send_request(CMD_GET, 32'hC4, 32'h0);
    send_request(CMD_GET, 32'hC5, 32'h0);
  endtask

  // a heavily used entry outlives fresh ones, back to back traffic
  task automatic test_heavy_use();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_capacity(5'd2);
    send_request(CMD_PUT, 32'h5A5A_5A5A, 32'd77);
    for (int i = 0; i < HEAVY_BUMPS; i++) send_request(CMD_GET, 32'h5A5A_5A5A, 32'h0);
    send_request(CMD_PUT, 32'hD1, 32'h1);
    send_request(CMD_PUT, 32'hD2, 32'h2);
    send_request(CMD_GET, 32'h5A5A_5A5A, 32'h0);
    send_request(CMD_GET, 32'hD1, 32'h0);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // receiver holds off long while requests keep coming
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    write_capacity(5'd4);
    hold_request = 300;
    for (int i = 0; i < 16; i++) begin
      send_request(1'($urandom_range(0, 1)), 32'hE0 + $urandom_range(0, 5), $urandom);
    end
    // sender pauses until every reply is back
    wait_drained();
    hold_request = 150;
    for (int i = 0; i < 12; i++) begin
      send_request(1'($urandom_range(0, 1)), 32'hE0 + $urandom_range(0, 5), $urandom);
    end
    src_idle_on = 1'b1;
  endtask

  // one capacity setting with traffic drawn mostly from a small key set
  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int count);
    logic [WORD_W-1:0] key_pool [$];
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
    int                pool_size;
    write_capacity(cap);
    pool_size = ((cap == 0) ? 1 : (cap > MAX_ENTRIES ? MAX_ENTRIES : int'(cap)))
                + $urandom_range(1, 4);
    for (int i = 0; i < pool_size; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool.push_back(32'h8000_0000);
        1:       key_pool.push_back(32'h7FFF_FFFF);
        2:       key_pool.push_back(32'hFFFF_FFFF);
        default: key_pool.push_back($urandom);
      endcase
    end
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: begin src_idle_on = 1'b1; sink_idle_on = 1'b1; end
          1: begin src_idle_on = 1'b1; sink_idle_on = 1'b0; end
          2: begin src_idle_on = 1'b0; sink_idle_on = 1'b1; end
          default: begin src_idle_on = 1'b0; sink_idle_on = 1'b0; end
        endcase
      end
      key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_size - 1)]
                                         : $urandom;
      case ($urandom_range(0, 19))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'h0000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      send_request(1'($urandom_range(0, 1)), key, value);
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_random();
    logic [CAP_W-1:0] caps [12];
    caps = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd3, 5'd5, 5'd8, 5'd12, 5'd0, 5'd0};
    caps[10] = CAP_W'($urandom_range(0, 31));
    caps[11] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < 12; p++) run_random_phase(caps[p], 120);
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        sink_wait    = hold_request;
        hold_request = 0;
      end
      if (sink_wait > 0) begin
        out_ready <= 1'b0;
        sink_wait--;
      end else if (sink_idle_on && $urandom_range(0, 99) < 30) begin
        out_ready <= 1'b0;
        sink_wait = stall_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each reply against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (reply_fifo.size() == 0) begin
        $display("%0t: reply with none pending, hit=%0b read_value=%h",
                 $time, out_item.hit, out_item.read_value);
        fail_count++;
      end else begin
        head_reply = reply_fifo.pop_front();
        if (out_item.hit !== head_reply.hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b",
                   $time, head_reply.hit, out_item.hit);
          fail_count++;
        end
        if (out_item.read_value !== head_reply.read_value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h",
                   $time, head_reply.read_value, out_item.read_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    cap_setting = CAPACITY_RESET;
    store_fill  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic();
    test_capacity_limits();
    test_eviction_order();
    test_heavy_use();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lfu_pkg.sv
design/lfu_store.sv
design/lfu_cmp_unit.sv
design/lfu_cache_replacement.sv
bench/tb.sv
